/* src/edd_pkg.sv */
// Shared types, constants and helpers for the RGB error-diffusion ditherer.
// No dependencies; used by edd_chan and error_diffusion_dither_rgb2bit_core.
`default_nettype none

package edd_pkg;

	// Geometry
	localparam int NCH      = 3;
	localparam int PIX_W    = 8;
	localparam int LVL_W    = 2;
	localparam int MAX_LINE = 1024;
	localparam int COL_W    = $clog2(MAX_LINE);
	localparam int LEN_W    = COL_W + 1;
	localparam int LEN_RESET = 300;

	// Error format: signed pixel units with ERR_FRAC fraction bits
	localparam int ERR_FRAC = 8;
	localparam int ERR_W    = ERR_FRAC + PIX_W + 1;
	localparam int V_W      = ERR_W + 1;
	localparam int X_W      = ERR_W + 2;
	localparam int P_W      = ERR_W + 4;
	localparam int ROW_W    = NCH * ERR_W;
	localparam int ERR_HI   = (1 << (ERR_W - 1)) - 1;
	localparam int ERR_LO   = -(1 << (ERR_W - 1));

	// Quantizer step and rounding thresholds (ties away from zero)
	localparam int STEP_D = 85 << ERR_FRAC;
	localparam int HALF_D = 85 << (ERR_FRAC - 1);
	localparam int TH1    = STEP_D - HALF_D;
	localparam int TH2    = 2 * STEP_D - HALF_D;
	localparam int TH3    = 3 * STEP_D - HALF_D;

	// Error store: two line banks back to back in one memory
	localparam int RAM_DEPTH = 2 * MAX_LINE;
	localparam int ADDR_W    = COL_W + 1;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef err_t [NCH-1:0] err_row_t;

	// Per-pixel control into each channel slice
	typedef struct packed {
		logic sof;
		logic eol;
	} ctl_t;

	// Clamp a widened error back into the stored range
	function automatic err_t sat_err(input logic signed [X_W-1:0] x);
		logic signed [X_W-1:0] hi;
		logic signed [X_W-1:0] lo;
		hi = X_W'(ERR_HI);
		lo = X_W'(ERR_LO);
		if (x > hi) begin
			return err_t'(hi);
		end else if (x < lo) begin
			return err_t'(lo);
		end
		return err_t'(x);
	endfunction

endpackage

`default_nettype wire

/* src/edd_ram.sv */
// Generic single-write, single-read memory with registered read data.
// No dependencies; holds the two line banks of the error store.
`default_nettype none

module edd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/edd_chan.sv */
// One color channel: quantize pixel plus diffused error, split the error into shares.
// Depends on edd_pkg for the error format, thresholds and saturation.
`default_nettype none

module edd_chan (
	input  wire logic [edd_pkg::PIX_W-1:0] pixel,
	input  wire edd_pkg::err_t             stored,
	input  wire edd_pkg::err_t             carry,
	input  wire edd_pkg::err_t             acc_prev,
	input  wire edd_pkg::err_t             acc_cur,
	input  wire edd_pkg::ctl_t             ctl,
	output logic [edd_pkg::LVL_W-1:0]      level,
	output edd_pkg::err_t                  carry_nx,
	output edd_pkg::err_t                  prev_fin,
	output edd_pkg::err_t                  cur_fin,
	output edd_pkg::err_t                  nxt_acc
);

	localparam int ERR_W = edd_pkg::ERR_W;
	localparam int V_W   = edd_pkg::V_W;
	localparam int X_W   = edd_pkg::X_W;
	localparam int P_W   = edd_pkg::P_W;
	localparam int ZPAD  = V_W - edd_pkg::PIX_W - edd_pkg::ERR_FRAC;

	localparam logic signed [V_W-1:0] PTH1 = V_W'(edd_pkg::TH1);
	localparam logic signed [V_W-1:0] PTH2 = V_W'(edd_pkg::TH2);
	localparam logic signed [V_W-1:0] PTH3 = V_W'(edd_pkg::TH3);
	localparam logic signed [V_W-1:0] NTH1 = V_W'(-edd_pkg::TH1);
	localparam logic signed [V_W-1:0] NTH2 = V_W'(-edd_pkg::TH2);
	localparam logic signed [V_W-1:0] NTH3 = V_W'(-edd_pkg::TH3);

	edd_pkg::err_t           carry_in;
	edd_pkg::err_t           prev_in;
	edd_pkg::err_t           cur_in;
	logic signed [X_W-1:0]   in_sum;
	edd_pkg::err_t           in_err;
	logic signed [V_W-1:0]   v;
	logic                    neg;
	logic [edd_pkg::LVL_W-1:0] q;
	logic signed [X_W-1:0]   mag;
	logic signed [X_W-1:0]   e_full;
	edd_pkg::err_t           e;
	logic signed [P_W-1:0]   ex;
	logic signed [P_W-1:0]   p7;
	logic signed [P_W-1:0]   p5;
	logic signed [P_W-1:0]   p3;
	edd_pkg::err_t           sh7;
	edd_pkg::err_t           sh5;
	edd_pkg::err_t           sh3;
	edd_pkg::err_t           sh1;

	// Drop carried and accumulated error on frame start
	assign carry_in = ctl.sof ? '0 : carry;
	assign prev_in  = ctl.sof ? '0 : acc_prev;
	assign cur_in   = ctl.sof ? '0 : acc_cur;

	// Combine stored and carried error, then add the scaled pixel
	assign in_sum = X_W'(stored) + X_W'(carry_in);
	assign in_err = edd_pkg::sat_err(in_sum);
	assign v = $signed({{ZPAD{1'b0}}, pixel, {edd_pkg::ERR_FRAC{1'b0}}}) + V_W'(in_err);
	assign neg = v[V_W-1];

	// Round magnitude to the nearest step, capped at three steps
	always_comb begin
		if (!neg) begin
			if (v >= PTH3) begin
				q = 2'd3;
			end else if (v >= PTH2) begin
				q = 2'd2;
			end else if (v >= PTH1) begin
				q = 2'd1;
			end else begin
				q = 2'd0;
			end
		end else begin
			if (v <= NTH3) begin
				q = 2'd3;
			end else if (v <= NTH2) begin
				q = 2'd2;
			end else if (v <= NTH1) begin
				q = 2'd1;
			end else begin
				q = 2'd0;
			end
		end
	end

	always_comb begin
		case (q)
			2'd0:    mag = '0;
			2'd1:    mag = X_W'(edd_pkg::STEP_D);
			2'd2:    mag = X_W'(2 * edd_pkg::STEP_D);
			2'd3:    mag = X_W'(3 * edd_pkg::STEP_D);
			default: mag = '0;
		endcase
	end

	// Quantization error against the signed level
	assign e_full = neg ? (X_W'(v) + mag) : (X_W'(v) - mag);
	assign e      = edd_pkg::sat_err(e_full);
	assign level  = neg ? '0 : q;

	// Floyd-Steinberg shares, rounded toward minus infinity
	assign ex  = P_W'(e);
	assign p7  = (ex <<< 3) - ex;
	assign p5  = (ex <<< 2) + ex;
	assign p3  = (ex <<< 1) + ex;
	assign sh7 = ERR_W'(p7 >>> 4);
	assign sh5 = ERR_W'(p5 >>> 4);
	assign sh3 = ERR_W'(p3 >>> 4);
	assign sh1 = ERR_W'(ex >>> 4);

	// Right neighbor and next-line window updates
	assign carry_nx = ctl.eol ? '0 : sh7;
	assign prev_fin = edd_pkg::sat_err(X_W'(prev_in) + X_W'(sh3));
	assign cur_fin  = edd_pkg::sat_err(X_W'(cur_in) + X_W'(sh5));
	assign nxt_acc  = sh1;

endmodule

`default_nettype wire

/* src/error_diffusion_dither_rgb2bit_core.sv */
// Top level of the RGB 2-bit error-diffusion ditherer: input stage, error store, result register.
// Depends on edd_pkg, edd_chan (one per color) and edd_ram (line error banks).
// Throughput: one pixel per cycle while out_ready is high or the result register is empty;
// the right-neighbor error loop closes in the s1 stage, and s2 registers the result.
// Reset: line length 300, column 0, all carried and stored error zero. The store needs
// no clearing pass: per-bank fill counts mark which entries hold error of the current frame.
`default_nettype none

module error_diffusion_dither_rgb2bit_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// pixel requests
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [edd_pkg::PIX_W-1:0]    red,
	input  wire logic [edd_pkg::PIX_W-1:0]    green,
	input  wire logic [edd_pkg::PIX_W-1:0]    blue,
	input  wire logic                         start_of_frame,
	// level results
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [edd_pkg::LVL_W-1:0]         red_level,
	output logic [edd_pkg::LVL_W-1:0]         green_level,
	output logic [edd_pkg::LVL_W-1:0]         blue_level,
	output logic                              end_of_line,
	// line length register
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [edd_pkg::LEN_W-1:0]    cfg_data
);

	localparam int NCH    = edd_pkg::NCH;
	localparam int COL_W  = edd_pkg::COL_W;
	localparam int LEN_W  = edd_pkg::LEN_W;
	localparam int ADDR_W = edd_pkg::ADDR_W;
	localparam int ROW_W  = edd_pkg::ROW_W;
	localparam int PIX_W  = edd_pkg::PIX_W;
	localparam int LVL_W  = edd_pkg::LVL_W;

	// Configuration and front-end position
	logic [LEN_W-1:0]  len_q;
	logic [COL_W-1:0]  col_q;
	logic              bank_q;
	logic [LEN_W-1:0]  fill_q [2];

	// Input stage
	logic                          valid_s1;
	logic [NCH-1:0][PIX_W-1:0]     pix_s1;
	logic                          sof_s1;
	logic                          eol_s1;
	logic [COL_W-1:0]              col_s1;
	logic                          bank_s1;
	logic                          rd_ok_s1;
	logic                          ovr_valid_s1;
	edd_pkg::err_row_t             ovr_s1;

	// Result stage
	logic                          valid_s2;
	logic [NCH-1:0][LVL_W-1:0]     lvl_s2;
	logic                          eol_s2;

	// Diffusion state
	edd_pkg::err_row_t             carry_q;
	edd_pkg::err_row_t             acc_prev_q;
	edd_pkg::err_row_t             acc_cur_q;
	logic                          pend_valid_q;
	logic                          pend_bank_q;
	logic [COL_W-1:0]              pend_col_q;
	edd_pkg::err_row_t             pend_data_q;

	logic                          in_fire;
	logic                          s1_go;
	logic [COL_W-1:0]              col_in;
	logic                          eol_in;
	logic [ADDR_W-1:0]             rd_addr;
	logic                          rd_ok_in;
	logic [ROW_W-1:0]              ram_q;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	edd_pkg::err_row_t             wr_data;
	logic                          wr_bank;
	logic [COL_W-1:0]              wr_col;
	logic [ADDR_W-1:0]             s1_addr;
	edd_pkg::err_row_t             stored_s1;
	edd_pkg::ctl_t                 ctl_s1;
	logic [LEN_W-1:0]              len_eff;
	logic [NCH-1:0][LVL_W-1:0]     lvl_c;
	edd_pkg::err_row_t             carry_nx;
	edd_pkg::err_row_t             prev_fin;
	edd_pkg::err_row_t             cur_fin;
	edd_pkg::err_row_t             nxt_acc;

	// Handshakes
	assign s1_go     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || s1_go;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Front end: column, line end and bank for the arriving pixel
	assign col_in   = start_of_frame ? '0 : col_q;
	assign eol_in   = ((LEN_W'(col_in) + LEN_W'(1)) >= len_q);
	assign rd_addr  = {bank_q, col_in};
	assign rd_ok_in = !start_of_frame && (LEN_W'(col_in) < fill_q[bank_q]);

	// Clip the written line length to the supported range
	always_comb begin
		if (cfg_data == '0) begin
			len_eff = LEN_W'(1);
		end else if (cfg_data > LEN_W'(edd_pkg::MAX_LINE)) begin
			len_eff = LEN_W'(edd_pkg::MAX_LINE);
		end else begin
			len_eff = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(edd_pkg::LEN_RESET);
		end else if (cfg_valid) begin
			len_q <= len_eff;
		end
	end

	// Advance column and bank on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			bank_q <= 1'b0;
		end else if (in_fire) begin
			col_q  <= eol_in ? '0 : COL_W'(col_in + COL_W'(1));
			bank_q <= bank_q ^ eol_in;
		end
	end

	// Memory write: a deferred line-end entry first, else the finished left entry
	assign wr_en   = pend_valid_q || (s1_go && (col_s1 != '0));
	assign wr_bank = pend_valid_q ? pend_bank_q : !bank_s1;
	assign wr_col  = pend_valid_q ? pend_col_q : COL_W'(col_s1 - COL_W'(1));
	assign wr_addr = {wr_bank, wr_col};
	assign wr_data = pend_valid_q ? pend_data_q : prev_fin;

	edd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (edd_pkg::RAM_DEPTH)
	) u_err_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (in_fire),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	// Fill counts: clear on frame start and when a bank turns into the next-line bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else begin
			for (int k = 0; k < 2; k++) begin
				if (in_fire && start_of_frame) begin
					fill_q[k] <= '0;
				end else if (s1_go && eol_s1 && (bank_s1 == 1'(k))) begin
					fill_q[k] <= '0;
				end else if (wr_en && (wr_bank == 1'(k))) begin
					fill_q[k] <= LEN_W'(wr_col) + LEN_W'(1);
				end
			end
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			ovr_valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1     <= 1'b1;
				ovr_valid_s1 <= wr_en && (wr_addr == rd_addr);
			end else begin
				if (s1_go) begin
					valid_s1 <= 1'b0;
				end
				if (valid_s1 && !s1_go && wr_en && (wr_addr == s1_addr)) begin
					ovr_valid_s1 <= 1'b1;
				end
			end
		end
	end

	// Input stage payload; catch writes to the entry being read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1   <= {blue, green, red};
			sof_s1   <= start_of_frame;
			eol_s1   <= eol_in;
			col_s1   <= col_in;
			bank_s1  <= bank_q;
			rd_ok_s1 <= rd_ok_in;
			ovr_s1   <= wr_data;
		end else if (valid_s1 && !s1_go && wr_en && (wr_addr == s1_addr)) begin
			ovr_s1 <= wr_data;
		end
	end

	assign s1_addr = {bank_s1, col_s1};

	// Stored error for this pixel: deferred entry, caught write, memory, or none
	always_comb begin
		if (sof_s1) begin
			stored_s1 = '0;
		end else if (pend_valid_q && ({pend_bank_q, pend_col_q} == s1_addr)) begin
			stored_s1 = pend_data_q;
		end else if (ovr_valid_s1) begin
			stored_s1 = ovr_s1;
		end else if (rd_ok_s1) begin
			stored_s1 = ram_q;
		end else begin
			stored_s1 = '0;
		end
	end

	assign ctl_s1.sof = sof_s1;
	assign ctl_s1.eol = eol_s1;

	// One slice per color
	for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
		edd_chan u_chan (
			.pixel    (pix_s1[ch]),
			.stored   (stored_s1[ch]),
			.carry    (carry_q[ch]),
			.acc_prev (acc_prev_q[ch]),
			.acc_cur  (acc_cur_q[ch]),
			.ctl      (ctl_s1),
			.level    (lvl_c[ch]),
			.carry_nx (carry_nx[ch]),
			.prev_fin (prev_fin[ch]),
			.cur_fin  (cur_fin[ch]),
			.nxt_acc  (nxt_acc[ch])
		);
	end

	// Diffusion state: right carry and the two open next-line entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q    <= '0;
			acc_prev_q <= '0;
			acc_cur_q  <= '0;
		end else if (s1_go) begin
			carry_q    <= carry_nx;
			acc_prev_q <= eol_s1 ? '0 : cur_fin;
			acc_cur_q  <= eol_s1 ? '0 : nxt_acc;
		end
	end

	// Hold back the last entry of a line as a deferred write; drop it on frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else begin
			pend_valid_q <= s1_go && eol_s1 && !(in_fire && start_of_frame);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && eol_s1) begin
			pend_bank_q <= !bank_s1;
			pend_col_q  <= col_s1;
			pend_data_q <= cur_fin;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			lvl_s2 <= lvl_c;
			eol_s2 <= eol_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign red_level   = lvl_s2[0];
	assign green_level = lvl_s2[1];
	assign blue_level  = lvl_s2[2];
	assign end_of_line = eol_s2;

`ifndef SYNTH
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !(s1_go && (col_s1 != '0)))
		else $error("deferred entry write collides with a pixel write");

	a_pend_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && eol_s1 && !(in_fire && start_of_frame)) |=> pend_valid_q)
		else $error("line end did not defer its last entry");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && eol_in) |=> (col_q == '0))
		else $error("column did not wrap after line end");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= LEN_W'(edd_pkg::MAX_LINE)) && (fill_q[1] <= LEN_W'(edd_pkg::MAX_LINE)))
		else $error("fill count beyond line capacity");
`endif

endmodule

`default_nettype wire
